// File: hw/rtl/pal_pkg.sv
// Shared constants, codes and types of the positional array list.
package pal_pkg;

   localparam int CAPACITY   = 1024;
   localparam int DATA_WIDTH = 32;

   localparam int CMD_W  = 2;
   localparam int POS_W  = 11;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 11;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Operation broadcast combinationally to every cell of the chain.
   typedef struct packed {
      logic                  ins;
      logic                  del;
      logic                  rd;
      logic [IDX_W-1:0]      slot;
      logic [DATA_WIDTH-1:0] value;
   } pal_cell_ctrl_type;

endpackage

// File: hw/rtl/pal_channels.sv
// Request and response channel interfaces of the positional array list.
interface pal_req_if;
   import pal_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [POS_W-1:0]      position;
   logic [DATA_WIDTH-1:0] value;

   modport source (output valid, cmd, position, value, input ready);
   modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface pal_rsp_if;
   import pal_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [STAT_W-1:0]     status;
   logic [DATA_WIDTH-1:0] read_value;
   logic [LEN_W-1:0]      length;

   modport source (output valid, status, read_value, length, input ready);
   modport sink   (input valid, status, read_value, length, output ready);
endinterface

// File: hw/rtl/pal_cell.sv
// One slot of the list: holds an element and passes data to its neighbors.
module pal_cell
   import pal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IDX_W-1:0]      index,
   input  pal_cell_ctrl_type     ctrl,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic                  right_rd_valid,
   input  logic [DATA_WIDTH-1:0] right_rd_data,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  rd_valid,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [DATA_WIDTH-1:0] rd_data_ff, rd_data_in;
   logic                  at_slot;
   logic                  past_slot;

   assign at_slot   = (index == ctrl.slot);
   assign past_slot = (index > ctrl.slot);

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (at_slot) begin
            data_in = ctrl.value;
         end else if (past_slot) begin
            data_in = left_data;
         end
      end else if (ctrl.del) begin
         if (at_slot || past_slot) begin
            data_in = right_data;
         end
      end
   end

   // A read word enters at the target cell and walks down toward slot zero.
   always_comb begin
      if (ctrl.rd && at_slot) begin
         rd_valid_in = 1'b1;
         rd_data_in  = data_ff;
      end else begin
         rd_valid_in = right_rd_valid;
         rd_data_in  = right_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff    <= data_in;
      rd_data_ff <= rd_data_in;
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign data     = data_ff;
   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

endmodule

// File: hw/rtl/positional_array_list.sv
// Top level of the positional array list: request checks, cell chain and response register.
//
//   channel    dir   handshake           payload
//   req_chan   in    valid/ready         cmd, position, value
//   rsp_chan   out   valid/ready         status, read_value, length
//
// Insert and delete shift the whole chain of cells in the accepting cycle; for these and
// every rejected request the response word is registered at that edge. For a get, the
// read word walks one cell per cycle down the chain to slot zero, and the response word
// is then registered from slot zero.
// Synchronous reset empties the list; the cells keep their contents.
// req_chan.ready is low while a get is in flight and while a response word waits
// and is not taken in the same cycle.
module positional_array_list
   import pal_pkg::*;
(
   input logic      clock,
   input logic      reset,
   pal_req_if.sink   req_chan,
   pal_rsp_if.source rsp_chan
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic                  state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0]      rsp_length_ff, rsp_length_in;
   logic                  rsp_load;

   logic                  req_fire;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      pos_m1;
   logic                  list_full;
   logic                  ins_bad;
   logic                  acc_bad;
   pal_cell_ctrl_type     ctrl;

   logic [DATA_WIDTH-1:0] cell_data    [CAPACITY];
   logic                  cell_rd_valid[CAPACITY];
   logic [DATA_WIDTH-1:0] cell_rd_data [CAPACITY];

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign pos_ext   = CMP_W'(req_chan.position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign pos_m1    = pos_ext - CMP_W'(1);
   assign list_full = (cnt_ext >= CMP_W'(CAPACITY));
   assign ins_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
   assign acc_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);

   always_comb begin
      ctrl          = '0;
      ctrl.slot     = pos_m1[IDX_W-1:0];
      ctrl.value    = req_chan.value;
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      if (req_fire) begin
         case (req_chan.cmd)
            CMD_INSERT: begin
               rsp_load = 1'b1;
               if (list_full) begin
                  rsp_status_in = ST_FULL;
               end else if (ins_bad) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  ctrl.ins = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_DELETE: begin
               rsp_load = 1'b1;
               if (acc_bad) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  ctrl.del = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_GET: begin
               if (acc_bad) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_RANGE;
               end else begin
                  ctrl.rd  = 1'b1;
                  state_in = S_READ;
               end
            end
            default: begin
               rsp_load      = 1'b1;
               rsp_status_in = ST_RANGE;
            end
         endcase
      end else if ((state_ff == S_READ) && cell_rd_valid[0]) begin
         rsp_load     = 1'b1;
         rsp_value_in = cell_rd_data[0];
         state_in     = S_IDLE;
      end
      rsp_length_in = LEN_W'(count_in);
      rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      logic                  right_rd_valid;
      logic [DATA_WIDTH-1:0] right_rd_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data     = '0;
         assign right_rd_valid = 1'b0;
         assign right_rd_data  = '0;
      end else begin : g_inner_r
         assign right_data     = cell_data[i+1];
         assign right_rd_valid = cell_rd_valid[i+1];
         assign right_rd_data  = cell_rd_data[i+1];
      end

      pal_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .index          (IDX_W'(i)),
         .ctrl           (ctrl),
         .left_data      (left_data),
         .right_data     (right_data),
         .right_rd_valid (right_rd_valid),
         .right_rd_data  (right_rd_data),
         .data           (cell_data[i]),
         .rd_valid       (cell_rd_valid[i]),
         .rd_data        (cell_rd_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_length_ff <= rsp_length_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.length     = rsp_length_ff;

`ifndef SYNTH
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("element count above capacity");

   a_token_only_in_read : assert property (@(posedge clock) disable iff (reset)
      cell_rd_valid[0] |-> (state_ff == S_READ))
      else $error("read word arrived with no get in flight");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

   a_read_ends_in_rsp : assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff) |-> rsp_valid_ff && (rsp_status_ff == ST_OK))
      else $error("get finished without a response word");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the positional array list: random words, predicted and compared.
module tb_top;
   import pal_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int POS_MAX = (1 << POS_W) - 1;

   typedef struct packed {
      logic [CMD_W-1:0]             cmd;
      logic [POS_W-1:0]             position;
      logic signed [DATA_WIDTH-1:0] value;
   } list_op_type;

   typedef struct packed {
      logic [STAT_W-1:0]            status;
      logic signed [DATA_WIDTH-1:0] read_value;
      logic [LEN_W-1:0]             length;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pal_req_if req_chan ();
   pal_rsp_if rsp_chan ();

   positional_array_list dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   list_op_type  op_pending_q[$];
   list_rsp_type rsp_expected_q[$];

   // Shadow of the list contents, advanced on every accepted request word.
   logic signed [DATA_WIDTH-1:0] list_slots [CAPACITY];
   int list_len = 0;
   // Length as the stimulus generator expects it, used to aim positions, pick commands and end fills and drains.
   int plan_len = 0;

   int  err_count = 0;
   int  src_idle_pct = 0;
   int  sink_stall_pct = 0;
   bit  req_took = 1'b0;

   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic list_rsp_type list_apply(input list_op_type op);
      list_rsp_type r;
      int p;
      r.status     = ST_OK;
      r.read_value = '0;
      p = int'(op.position);
      case (op.cmd)
         CMD_INSERT: begin
            if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (p < 1 || p > list_len + 1) begin
               r.status = ST_RANGE;
            end else begin
               for (int j = list_len; j >= p; j--) list_slots[j] = list_slots[j-1];
               list_slots[p-1] = op.value;
               list_len++;
            end
         end
         CMD_DELETE: begin
            if (p < 1 || p > list_len) begin
               r.status = ST_RANGE;
            end else begin
               for (int j = p - 1; j + 1 < list_len; j++) list_slots[j] = list_slots[j+1];
               list_len--;
            end
         end
         CMD_GET: begin
            if (p < 1 || p > list_len) r.status = ST_RANGE;
            else r.read_value = list_slots[p-1];
         end
         default: r.status = ST_RANGE;
      endcase
      r.length = LEN_W'(list_len);
      return r;
   endfunction

   task automatic queue_op(input logic [CMD_W-1:0] cmd, input int pos,
                           input logic [DATA_WIDTH-1:0] val);
      list_op_type op;
      op.cmd      = cmd;
      op.position = POS_W'(pos);
      op.value    = val;
      op_pending_q.push_back(op);
      if (cmd == CMD_INSERT && plan_len < CAPACITY && pos >= 1 && pos <= plan_len + 1)
         plan_len++;
      else if (cmd == CMD_DELETE && pos >= 1 && pos <= plan_len)
         plan_len--;
   endtask

   // Mostly legal operations on a short list, with out-of-range positions and noise mixed in.
   task automatic queue_random(input int count);
      int roll;
      int pos;
      logic [CMD_W-1:0] cmd;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            queue_op(CMD_W'($urandom_range(3)), $urandom_range(POS_MAX), $urandom);
         end else begin
            roll = $urandom_range(99);
            if (plan_len < 8) cmd = (roll < 60) ? CMD_INSERT : (roll < 80) ? CMD_GET : CMD_DELETE;
            else if (plan_len > 56) cmd = (roll < 50) ? CMD_DELETE : (roll < 80) ? CMD_GET
                                                                   : CMD_INSERT;
            else cmd = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_DELETE : CMD_GET;
            roll = $urandom_range(99);
            if (roll < 6) pos = 0;
            else if (roll < 12) pos = plan_len + 1 + $urandom_range(1);
            else if (cmd == CMD_INSERT) pos = $urandom_range(plan_len + 1, 1);
            else pos = (plan_len == 0) ? 1 : $urandom_range(plan_len, 1);
            queue_op(cmd, pos, $urandom);
         end
      end
   endtask

   // Grow the list to the target length with a few gets, some past the end, mixed in.
   task automatic queue_fill(input int target);
      while (plan_len < target) begin
         if ($urandom_range(63) == 0) queue_op(CMD_GET, $urandom_range(plan_len + 1), 0);
         else queue_op(CMD_INSERT, $urandom_range(plan_len + 1, 1), $urandom);
      end
   endtask

   // Probe the full list and the far end of it.
   task automatic queue_full_probes;
      queue_op(CMD_INSERT, 1, $urandom);
      queue_op(CMD_INSERT, CAPACITY + 1, $urandom);
      queue_op(CMD_INSERT, 0, $urandom);
      queue_op(CMD_INSERT, POS_MAX, $urandom);
      queue_op(CMD_GET, CAPACITY, 0);
      queue_op(CMD_GET, CAPACITY - 1, 0);
      queue_op(CMD_GET, 1, 0);
      queue_op(CMD_GET, CAPACITY + 1, 0);
      queue_op(CMD_GET, POS_MAX, 0);
      queue_op(CMD_DELETE, CAPACITY + 1, 0);
      queue_op(CMD_DELETE, CAPACITY, 0);
      queue_op(CMD_GET, CAPACITY, 0);
      queue_op(CMD_INSERT, CAPACITY, $urandom);
      queue_op(CMD_GET, CAPACITY, 0);
      queue_op(CMD_INSERT, CAPACITY, $urandom);
      queue_op(CMD_DELETE, 1, 0);
      queue_op(CMD_GET, 1, 0);
   endtask

   // Shrink the list to the target length with a few gets near the front.
   task automatic queue_drain(input int target);
      while (plan_len > target) begin
         if ($urandom_range(63) == 0) queue_op(CMD_GET, $urandom_range(8), 0);
         else queue_op(CMD_DELETE, $urandom_range(plan_len, 1), 0);
      end
   endtask

   task automatic wait_drained;
      while (op_pending_q.size() != 0 || req_chan.valid || rsp_expected_q.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Request driver: a word stays on the channel until it is taken.
   always @(negedge clock) begin
      list_op_type op;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_took) begin
         if (op_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            op = op_pending_q.pop_front();
            req_chan.valid    <= 1'b1;
            req_chan.cmd      <= op.cmd;
            req_chan.position <= op.position;
            req_chan.value    <= op.value;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= reset || ($urandom_range(99) >= sink_stall_pct);
   end

   // Monitor: checks the response word first, then predicts for the request taken at this edge.
   always @(posedge clock) begin
      list_op_type  op;
      list_rsp_type want;
      req_took = !reset && req_chan.valid && req_chan.ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rsp_expected_q.size() == 0) begin
            report($sformatf("unexpected response status=%0d value=%0d length=%0d",
                             rsp_chan.status, $signed(rsp_chan.read_value), rsp_chan.length));
         end else begin
            want = rsp_expected_q.pop_front();
            if (rsp_chan.status !== want.status)
               report($sformatf("status got %0d want %0d", rsp_chan.status, want.status));
            if (rsp_chan.read_value !== want.read_value)
               report($sformatf("read_value got %0d want %0d",
                                $signed(rsp_chan.read_value), want.read_value));
            if (rsp_chan.length !== want.length)
               report($sformatf("length got %0d want %0d", rsp_chan.length, want.length));
         end
      end
      if (req_took) begin
         op.cmd      = req_chan.cmd;
         op.position = req_chan.position;
         op.value    = req_chan.value;
         rsp_expected_q.push_back(list_apply(op));
      end
   end

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.cmd      = CMD_INSERT;
      req_chan.position = '0;
      req_chan.value    = '0;
      rsp_chan.ready    = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, starting from the empty list.
      queue_op(CMD_GET, 1, 0);
      queue_op(CMD_DELETE, 1, 0);
      queue_op(CMD_INSERT, 0, 32'h1234_5678);
      queue_op(CMD_INSERT, 2, 32'h1234_5678);
      queue_op(CMD_UNUSED, 1, 32'hffff_ffff);
      queue_op(CMD_INSERT, 1, 32'h7fff_ffff);
      queue_op(CMD_INSERT, 1, 32'h8000_0000);
      queue_op(CMD_INSERT, 3, 32'h0000_0000);
      queue_op(CMD_INSERT, 2, 32'hffff_ffff);
      queue_op(CMD_INSERT, POS_MAX, 32'h5555_aaaa);
      queue_op(CMD_GET, 1, 0);
      queue_op(CMD_GET, 4, 0);
      queue_op(CMD_GET, 2, 0);
      queue_op(CMD_GET, 5, 0);
      queue_op(CMD_GET, 0, 0);
      queue_op(CMD_DELETE, 5, 0);
      queue_op(CMD_DELETE, 0, 0);
      queue_op(CMD_DELETE, 4, 0);
      queue_op(CMD_DELETE, 1, 0);
      queue_op(CMD_GET, 1, 0);
      queue_op(CMD_GET, 2, 0);
      queue_op(CMD_UNUSED, POS_MAX, 32'hffff_ffff);
      queue_op(CMD_DELETE, 1, 0);
      queue_op(CMD_DELETE, 1, 0);
      queue_op(CMD_GET, 1, 0);
      wait_drained();

      // One fill to capacity and drain back to empty, spread over phases with different idle and stall rates.
      src_idle_pct = 0;  sink_stall_pct = 0;
      queue_random(80);
      queue_fill(CAPACITY / 2);
      wait_drained();
      src_idle_pct = 78; sink_stall_pct = 0;
      queue_fill(CAPACITY);
      queue_full_probes();
      wait_drained();
      src_idle_pct = 0;  sink_stall_pct = 78;
      queue_drain(CAPACITY / 2);
      wait_drained();
      src_idle_pct = 7;  sink_stall_pct = 7;
      queue_drain(0);
      queue_random(80);
      wait_drained();

      // Long enough for a get at the far end to show a stray response.
      repeat (CAPACITY + 16) @(posedge clock);
      if (rsp_expected_q.size() != 0)
         report($sformatf("%0d responses never arrived", rsp_expected_q.size()));
      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
